// ===== src/kpd_pkg.sv =====
// shared constants and types for the key packet deframer with key fifo
`default_nettype none

package kpd_pkg;

  // default number of keys the fifo holds
  localparam int unsigned FifoDepthDefault = 16;

  // request codes carried by req_type
  localparam logic ReqByte = 1'b0;
  localparam logic ReqPop  = 1'b1;

  // frame values that mark a key frame
  localparam logic [7:0] KeyCommand = 8'h80;
  localparam logic [7:0] KeyLength  = 8'h01;
  localparam logic [7:0] KeyMin     = 8'h01;
  localparam logic [7:0] KeyMax     = 8'h06;

  // error flag bit positions
  localparam int unsigned ErrOverflowBit = 0;
  localparam int unsigned ErrEmptyBit    = 1;

  // field widths
  localparam int unsigned KeyWidth   = 3;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned ErrWidth   = 2;

  // parser phases
  typedef enum logic [4:0] {
    PH_CMD    = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_CRC_LO = 5'b01000,
    PH_CRC_HI = 5'b10000
  } phase_e;

endpackage

`default_nettype wire

// ===== src/key_packet_deframer_fifo.sv =====
// key packet deframer: frame parser feeding a key fifo held in a synchronous ram
//
// Input channel (in_valid_i / in_stall_o) carries one request per item:
// req_type_i = 0 hands in one received frame byte on rx_byte_i, req_type_i = 1
// pops the oldest queued key. Frames are command, length, length data bytes
// and two crc bytes; the crc is skipped. A frame with command 0x80, length 1
// and a first data byte of 1 to 6 queues that key when its last crc byte
// arrives. Every request yields exactly one result on the output channel
// (out_valid_o / out_stall_i): popped key, key-queued flag, sticky error
// flags and the fifo fill level after the request.
// The result register loads at the edge that takes the request, and the key
// ram read issued at that same edge lands in the ram output register together
// with it. One request per cycle is taken while the result register is empty
// or being drained; the single result register sets this figure. While the
// receiver stalls a waiting result, in_stall_o is high and the result holds.
// Reset empties the fifo, clears the flags and returns the parser to the
// command byte; the key ram itself is not cleared, entries are only read
// after they have been written.
`default_nettype none

module key_packet_deframer_fifo #(
  parameter int unsigned FIFO_DEPTH = kpd_pkg::FifoDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            req_type_i,
  input  wire logic [kpd_pkg::ByteWidth-1:0]   rx_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [kpd_pkg::KeyWidth-1:0]    key_out_o,
  output logic                                 key_pushed_o,
  output logic      [kpd_pkg::ErrWidth-1:0]    error_flags_o,
  output logic      [kpd_pkg::CountWidth-1:0]  key_count_o
);

  localparam int unsigned IdxWidth  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FillWidth = $clog2(FIFO_DEPTH + 1);
  localparam logic [IdxWidth-1:0]  IdxLast  = IdxWidth'(FIFO_DEPTH - 1);
  localparam logic [FillWidth-1:0] FillFull = FillWidth'(FIFO_DEPTH);

  // key ram
  logic [kpd_pkg::KeyWidth-1:0] key_mem [FIFO_DEPTH];
  logic [kpd_pkg::KeyWidth-1:0] rd_data_q;

  // parser state
  kpd_pkg::phase_e              phase_q, phase_d;
  logic [kpd_pkg::ByteWidth-1:0] seen_q, seen_d;
  logic [kpd_pkg::ByteWidth-1:0] len_q, len_d;
  logic                         cmd_key_q, cmd_key_d;
  logic                         data_ok_q, data_ok_d;
  logic [kpd_pkg::KeyWidth-1:0] data_key_q, data_key_d;

  // fifo control state
  logic [IdxWidth-1:0]          wr_idx_q, wr_idx_d;
  logic [IdxWidth-1:0]          rd_idx_q, rd_idx_d;
  logic [FillWidth-1:0]         fill_q, fill_d;
  logic [kpd_pkg::ErrWidth-1:0] err_q, err_d;

  // result register
  logic out_valid_q;
  logic out_pop_q, out_pop_d;
  logic out_pushed_q, out_pushed_d;

  logic in_take;
  logic is_pop;
  logic push_en;
  logic pop_en;
  logic fifo_full;
  logic fifo_empty;
  logic key_frame;
  logic [kpd_pkg::ByteWidth-1:0] seen_inc;
  logic [FillWidth+kpd_pkg::CountWidth-1:0] fill_ext;

  // handshake: take a request whenever the result register can be reloaded
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign is_pop     = (req_type_i == kpd_pkg::ReqPop);

  assign fifo_full  = (fill_q == FillFull);
  assign fifo_empty = (fill_q == '0);
  assign seen_inc   = seen_q + 8'd1;
  assign key_frame  = cmd_key_q & (len_q == kpd_pkg::KeyLength) & data_ok_q;

  assign push_en = in_take & ~is_pop & (phase_q == kpd_pkg::PH_CRC_HI) & key_frame &
                   ~fifo_full;
  assign pop_en  = in_take & is_pop & ~fifo_empty;

  // frame parser
  always_comb begin
    phase_d    = phase_q;
    seen_d     = seen_q;
    len_d      = len_q;
    cmd_key_d  = cmd_key_q;
    data_ok_d  = data_ok_q;
    data_key_d = data_key_q;
    if (in_take && !is_pop) begin
      case (phase_q)
        kpd_pkg::PH_CMD: begin
          cmd_key_d = (rx_byte_i == kpd_pkg::KeyCommand);
          phase_d   = kpd_pkg::PH_LEN;
        end
        kpd_pkg::PH_LEN: begin
          len_d   = rx_byte_i;
          seen_d  = '0;
          phase_d = (rx_byte_i == '0) ? kpd_pkg::PH_CRC_LO : kpd_pkg::PH_DATA;
        end
        kpd_pkg::PH_DATA: begin
          if (seen_q == '0) begin
            data_ok_d  = rx_byte_i inside {[kpd_pkg::KeyMin:kpd_pkg::KeyMax]};
            data_key_d = rx_byte_i[kpd_pkg::KeyWidth-1:0];
          end
          seen_d = seen_inc;
          if (seen_inc == len_q) begin
            phase_d = kpd_pkg::PH_CRC_LO;
          end
        end
        kpd_pkg::PH_CRC_LO: begin
          phase_d = kpd_pkg::PH_CRC_HI;
        end
        default: begin
          phase_d = kpd_pkg::PH_CMD;
        end
      endcase
    end
  end

  // fifo pointers, fill level and sticky flags
  always_comb begin
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    fill_d       = fill_q;
    err_d        = err_q;
    out_pop_d    = out_pop_q;
    out_pushed_d = out_pushed_q;
    if (in_take) begin
      out_pop_d    = pop_en;
      out_pushed_d = push_en;
      if (push_en) begin
        wr_idx_d = (wr_idx_q == IdxLast) ? '0 : wr_idx_q + 1'b1;
        fill_d   = fill_q + 1'b1;
        err_d    = '0;
      end else if (pop_en) begin
        rd_idx_d = (rd_idx_q == IdxLast) ? '0 : rd_idx_q + 1'b1;
        fill_d   = fill_q - 1'b1;
        err_d    = '0;
      end else if (is_pop) begin
        err_d[kpd_pkg::ErrEmptyBit] = 1'b1;
      end else if ((phase_q == kpd_pkg::PH_CRC_HI) && key_frame) begin
        err_d[kpd_pkg::ErrOverflowBit] = 1'b1;
      end
    end
  end

  // key ram: write on push, registered read on pop
  // a pop only reads entries written at an earlier edge, so no forwarding
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      key_mem[wr_idx_q] <= data_key_q;
    end
    if (pop_en) begin
      rd_data_q <= key_mem[rd_idx_q];
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= kpd_pkg::PH_CMD;
      seen_q       <= '0;
      len_q        <= '0;
      cmd_key_q    <= 1'b0;
      data_ok_q    <= 1'b0;
      data_key_q   <= '0;
      wr_idx_q     <= '0;
      rd_idx_q     <= '0;
      fill_q       <= '0;
      err_q        <= '0;
      out_valid_q  <= 1'b0;
      out_pop_q    <= 1'b0;
      out_pushed_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      seen_q       <= seen_d;
      len_q        <= len_d;
      cmd_key_q    <= cmd_key_d;
      data_ok_q    <= data_ok_d;
      data_key_q   <= data_key_d;
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      fill_q       <= fill_d;
      err_q        <= err_d;
      out_pop_q    <= out_pop_d;
      out_pushed_q <= out_pushed_d;
      if (in_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result outputs
  assign fill_ext      = {{kpd_pkg::CountWidth{1'b0}}, fill_q};
  assign out_valid_o   = out_valid_q;
  assign key_out_o     = out_pop_q ? rd_data_q : '0;
  assign key_pushed_o  = out_pushed_q;
  assign error_flags_o = err_q;
  assign key_count_o   = fill_ext[kpd_pkg::CountWidth-1:0];

  // fill level never passes the fifo depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillFull)
    else $error("fill level above fifo depth");

  // overflow and empty flags are never set together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_flags_o != 2'b11))
    else $error("both error flags set");

  // a queued key clears both flags and grows the fill level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |=> (err_q == '0) && (fill_q == $past(fill_q) + 1'b1))
    else $error("push did not update fill level and flags");

  // a pop and a push never come from the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_pop_q && out_pushed_q))
    else $error("pop and push in one result");

endmodule

`default_nettype wire
